FILE: rtl/tdfe_pkg.sv
// Package for the timer digit frame encoder.
// Holds the request and result types and the frame constants; no dependencies.
`timescale 1ns / 1ps

package tdfe_pkg;

    // Input request: command byte, elapsed time, generation select
    typedef struct packed {
        logic [7:0]  command_byte;
        logic [19:0] elapsed_ms;
        logic        third_generation;
    } t_in_item;

    // One frame byte with its end-of-frame flags
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_idle;
        logic       last;
    } t_out_item;

    // Time units in milliseconds, one per digit place
    localparam logic [19:0] MS_PER_MINUTE    = 20'd60000;
    localparam logic [19:0] MS_PER_TEN_SEC   = 20'd10000;
    localparam logic [19:0] MS_PER_SECOND    = 20'd1000;
    localparam logic [19:0] MS_PER_TENTH     = 20'd100;
    localparam logic [19:0] MS_PER_HUNDREDTH = 20'd10;
    localparam logic [19:0] MS_PER_MS        = 20'd1;

    // Saturation limit: 9:59.999
    localparam logic [19:0] MAX_TIME_MS = 20'd599999;

    // Frame byte constants
    localparam logic [6:0] CHECK_BASE = 7'd64;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_IDLE  = 8'h00;

endpackage

FILE: rtl/tdfe_in_reg.sv
// Input holding register for the timer digit frame encoder.
// Holds one request until the frame sequencer loads it; uses tdfe_pkg.
`timescale 1ns / 1ps

module tdfe_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tdfe_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output tdfe_pkg::t_in_item o_item
);
    import tdfe_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     w_accept;

    // Stall while a held request is not being taken this cycle
    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/tdfe_frame_seq.sv
// Frame sequencer: walks the frame one byte per step, peeling one decimal
// digit off the remaining time at each digit place. Uses tdfe_pkg.
`timescale 1ns / 1ps

module tdfe_frame_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  tdfe_pkg::t_in_item i_in_item,
    output logic               o_load,
    output logic               o_valid,
    input  logic               i_take,
    output tdfe_pkg::t_out_item o_item
);
    import tdfe_pkg::*;

    typedef enum logic [3:0] {
        POS_CMD,
        POS_MIN,
        POS_TSEC,
        POS_SEC,
        POS_TENTH,
        POS_HUND,
        POS_THOU,
        POS_CHECK,
        POS_LF,
        POS_CR,
        POS_IDLE
    } t_pos;

    // Digit of value in one place: count the multiples of unit it reaches
    function automatic logic [3:0] f_digit(input logic [19:0] value,
                                           input logic [19:0] unit);
        logic [3:0]  digit;
        logic [19:0] limit;
        digit = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            limit = 20'(32'(k) * 32'(unit));
            if (value >= limit) begin
                digit = 4'(k);
            end
        end
        return digit;
    endfunction

    logic        r_busy;
    t_pos        r_pos;
    logic [19:0] r_rem;
    logic [6:0]  r_sum;
    logic [7:0]  r_cmd;
    logic        r_gen3;

    t_pos        n_pos;
    logic [3:0]  w_digit;
    logic [19:0] w_unit;
    logic        w_is_digit;
    logic [19:0] w_sat_ms;

    // Load a new request when idle or when the idle marker leaves
    assign o_load = i_in_valid && (!r_busy || (i_take && r_pos == POS_IDLE));

    assign w_sat_ms = (i_in_item.elapsed_ms > MAX_TIME_MS) ? MAX_TIME_MS
                                                           : i_in_item.elapsed_ms;

    // Select the unit of the current digit place
    always_comb begin
        w_is_digit = 1'b1;
        w_unit     = MS_PER_MS;
        unique case (r_pos)
            POS_MIN:   w_unit = MS_PER_MINUTE;
            POS_TSEC:  w_unit = MS_PER_TEN_SEC;
            POS_SEC:   w_unit = MS_PER_SECOND;
            POS_TENTH: w_unit = MS_PER_TENTH;
            POS_HUND:  w_unit = MS_PER_HUNDREDTH;
            POS_THOU:  w_unit = MS_PER_MS;
            default:   w_is_digit = 1'b0;
        endcase
    end

    // Extract the digit of the current place
    always_comb begin
        w_digit = 4'd0;
        unique case (r_pos)
            POS_MIN:   w_digit = f_digit(r_rem, MS_PER_MINUTE);
            POS_TSEC:  w_digit = f_digit(r_rem, MS_PER_TEN_SEC);
            POS_SEC:   w_digit = f_digit(r_rem, MS_PER_SECOND);
            POS_TENTH: w_digit = f_digit(r_rem, MS_PER_TENTH);
            POS_HUND:  w_digit = f_digit(r_rem, MS_PER_HUNDREDTH);
            POS_THOU:  w_digit = f_digit(r_rem, MS_PER_MS);
            default:   w_digit = 4'd0;
        endcase
    end

    // Advance through the frame, dropping the thousandths in generation 2
    always_comb begin
        n_pos = r_pos;
        unique case (r_pos)
            POS_CMD:   n_pos = POS_MIN;
            POS_MIN:   n_pos = POS_TSEC;
            POS_TSEC:  n_pos = POS_SEC;
            POS_SEC:   n_pos = POS_TENTH;
            POS_TENTH: n_pos = POS_HUND;
            POS_HUND:  n_pos = r_gen3 ? POS_THOU : POS_CHECK;
            POS_THOU:  n_pos = POS_CHECK;
            POS_CHECK: n_pos = POS_LF;
            POS_LF:    n_pos = POS_CR;
            POS_CR:    n_pos = POS_IDLE;
            default:   n_pos = POS_CMD;
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= POS_CMD;
        end else if (o_load) begin
            r_busy <= 1'b1;
            r_pos  <= POS_CMD;
        end else if (i_take) begin
            if (r_pos == POS_IDLE) begin
                r_busy <= 1'b0;
            end
            r_pos <= n_pos;
        end
    end

    // Hold frame payload: remaining time, running checksum, command
    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_rem  <= w_sat_ms;
            r_sum  <= CHECK_BASE;
            r_cmd  <= i_in_item.command_byte;
            r_gen3 <= i_in_item.third_generation;
        end else if (i_take && w_is_digit) begin
            r_rem <= r_rem - 20'(32'(w_digit) * 32'(w_unit));
            r_sum <= r_sum + 7'(w_digit);
        end
    end

    // Form the current frame byte
    always_comb begin
        o_item.is_idle = 1'b0;
        o_item.last    = 1'b0;
        unique case (r_pos)
            POS_CMD:   o_item.out_byte = r_cmd;
            POS_CHECK: o_item.out_byte = {1'b0, r_sum};
            POS_LF:    o_item.out_byte = BYTE_LF;
            POS_CR:    o_item.out_byte = BYTE_CR;
            POS_IDLE: begin
                o_item.out_byte = BYTE_IDLE;
                o_item.is_idle  = 1'b1;
                o_item.last     = 1'b1;
            end
            default:   o_item.out_byte = ASCII_ZERO + 8'(w_digit);
        endcase
    end

    assign o_valid = r_busy;

endmodule

FILE: rtl/timer_digit_frame_encoder_top.sv
// Top level of the timer digit frame encoder.
// Instantiates tdfe_in_reg and tdfe_frame_seq and holds the result register;
// uses tdfe_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one request: a
//   command byte, an elapsed time in ms and a generation select. Output
//   channel (o_out_valid / i_out_stall / o_out_item) returns the frame one
//   byte per result: command, digits (M, 10s, s, 0.1s, 0.01s and, in
//   generation 3, 0.001s), checksum, LF, CR, then the idle marker flagged as
//   last. Times above 9:59.999 saturate to 599999 ms.
//   An accepted request passes through the input register, the sequencer
//   and the result register before its command byte appears. A frame is
//   10 bytes in generation 2 and 11 in generation 3, one frame byte per
//   cycle while the receiver does not stall; the input register takes the
//   next request while a frame is going out, and frames follow without gaps.
//   Reset clears the input register, sequencer and result register valid
//   flags. While the receiver stalls, the result register holds its byte,
//   the sequencer holds its place and the input register fills and stalls.
`timescale 1ns / 1ps

module timer_digit_frame_encoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tdfe_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tdfe_pkg::t_out_item o_out_item
);
    import tdfe_pkg::*;

    logic      w_held_valid;
    t_in_item  w_held_item;
    logic      w_load;
    logic      w_seq_valid;
    t_out_item w_seq_item;
    logic      w_take;

    logic      r_out_valid;
    t_out_item r_out_item;

    tdfe_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (w_held_valid),
        .i_take  (w_load),
        .o_item  (w_held_item)
    );

    tdfe_frame_seq u_frame_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (w_held_valid),
        .i_in_item  (w_held_item),
        .o_load     (w_load),
        .o_valid    (w_seq_valid),
        .i_take     (w_take),
        .o_item     (w_seq_item)
    );

    // Move a byte into the result register when it is empty or draining
    assign w_take = w_seq_valid && (!r_out_valid || !i_out_stall);

    // Hold result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture result payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_item <= w_seq_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/tdfe_checker.sv
// Port-level checker for the timer digit frame encoder, bound to the top.
// Depends on tdfe_pkg and timer_digit_frame_encoder_top.
`timescale 1ns / 1ps

module tdfe_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input tdfe_pkg::t_out_item o_out_item
);
    import tdfe_pkg::*;

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // Idle marker and last flag go together
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.is_idle == o_out_item.last)
        else $error("is_idle and last disagree");

    // Idle marker carries a zero byte
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last |-> o_out_item.out_byte == BYTE_IDLE)
        else $error("idle marker byte not zero");

    // A frame end is never followed directly by another frame end
    a_no_double_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_item.last
        |=> !(o_out_valid && o_out_item.last))
        else $error("frame end repeated");

endmodule

bind timer_digit_frame_encoder_top tdfe_checker u_tdfe_checker (.*);
